@@ rtl/ssp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssp_pkg
// Shared constants, types and sequencer states for the shortest path block.
// ---------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned NUM_VERTICES = 16;
  localparam int unsigned WEIGHT_BITS  = 16;

  localparam int unsigned VERT_BITS = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned CNT_BITS  = $clog2(NUM_VERTICES + 1);
  localparam int unsigned ADDR_BITS = 2 * VERT_BITS;

  localparam longint unsigned DIST_MAX =
    64'(NUM_VERTICES - 1) * ((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam int unsigned DIST_BITS = $clog2(DIST_MAX + 64'd1);

  // Fixed port field widths
  localparam int unsigned IDX_IN_BITS     = 4;
  localparam int unsigned WEIGHT_IN_BITS  = 16;
  localparam int unsigned VERTEX_OUT_BITS = 4;
  localparam int unsigned OUT_DIST_BITS   = 20;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_RELAX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [DIST_BITS-1:0]   base;
    logic [WEIGHT_BITS-1:0] addend;
    logic [DIST_BITS-1:0]   ref_dist;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] sum;
    logic                 lt;
    logic                 eq;
  } alu_rsp_t;

endpackage

@@ rtl/ssp_edge_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssp_edge_ram
// Single write, single read RAM with registered read data for edge weights.
// ---------------------------------------------------------------------------
module ssp_edge_ram #(
  parameter int unsigned ADDR_BITS = 8,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [(1 << ADDR_BITS)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/ssp_alu.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssp_alu
// Shared add and compare unit: sum = base + addend, compared to ref_dist.
// ---------------------------------------------------------------------------
module ssp_alu
  import ssp_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [DIST_BITS-1:0] sum;

  assign sum       = req_i.base + DIST_BITS'(req_i.addend);
  assign rsp_o.sum = sum;
  assign rsp_o.lt  = sum < req_i.ref_dist;
  assign rsp_o.eq  = sum == req_i.ref_dist;

endmodule

@@ rtl/ssp_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssp_seq
// Sequencer: vertex pick scan, edge relaxation and result emission.
// ---------------------------------------------------------------------------
module ssp_seq
  import ssp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind_i,
  input  logic [IDX_IN_BITS-1:0]     row_i,
  input  logic [IDX_IN_BITS-1:0]     column_i,
  input  logic [WEIGHT_IN_BITS-1:0]  weight_i,
  input  logic [IDX_IN_BITS-1:0]     source_vertex_i,
  output logic                       ram_we_o,
  output logic [ADDR_BITS-1:0]       ram_waddr_o,
  output logic [WEIGHT_BITS-1:0]     ram_wdata_o,
  output logic [ADDR_BITS-1:0]       ram_raddr_o,
  input  logic [WEIGHT_BITS-1:0]     ram_rdata_i,
  output alu_req_t                   alu_req_o,
  input  alu_rsp_t                   alu_rsp_i,
  output logic                       valid_o,
  output logic [VERTEX_OUT_BITS-1:0] vertex_o,
  output logic [OUT_DIST_BITS-1:0]   distance_o,
  output logic                       reachable_o,
  output logic                       last_o
);

  state_e state_q, state_d;

  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic [VERT_BITS-1:0]    round_q, round_d;
  logic [VERT_BITS-1:0]    u_q, u_d;
  logic                    have_q, have_d;
  logic                    best_reached_q, best_reached_d;
  logic [VERT_BITS-1:0]    best_q, best_d;
  logic [DIST_BITS-1:0]    best_dist_q, best_dist_d;
  logic [NUM_VERTICES-1:0] reached_q, reached_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic                    pv_valid_q, pv_valid_d;
  logic [VERT_BITS-1:0]    pv_idx_q, pv_idx_d;
  logic [DIST_BITS-1:0]    dist_q [NUM_VERTICES];

  logic                    dist_we;
  logic [VERT_BITS-1:0]    dist_widx;
  logic [DIST_BITS-1:0]    dist_wdata;

  logic                       valid_d;
  logic [VERTEX_OUT_BITS-1:0] vertex_d;
  logic [OUT_DIST_BITS-1:0]   distance_d;
  logic                       reachable_d;
  logic                       last_d;

  logic                 accept;
  logic                 cnt_end;
  logic                 last_round;
  logic [VERT_BITS-1:0] v_idx;
  logic [VERT_BITS-1:0] src_idx;
  logic                 take;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign cnt_end    = (cnt_q == CNT_BITS'(NUM_VERTICES));
  assign last_round = (round_q == VERT_BITS'(NUM_VERTICES - 2));
  assign v_idx      = cnt_q[VERT_BITS-1:0];
  assign src_idx    = VERT_BITS'(source_vertex_i);

  assign ram_we_o    = accept && (kind_i == KIND_LOAD) &&
                       (32'(row_i) < NUM_VERTICES) && (32'(column_i) < NUM_VERTICES);
  assign ram_waddr_o = {VERT_BITS'(row_i), VERT_BITS'(column_i)};
  assign ram_wdata_o = WEIGHT_BITS'(weight_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_RUN)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (cnt_end) begin
          if (best_reached_q) begin
            state_d = ST_RELAX;
          end else if (last_round) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_RELAX: begin
        if (cnt_end) begin
          state_d = last_round ? ST_EMIT : ST_PICK;
        end
      end
      ST_EMIT: begin
        if (cnt_q == CNT_BITS'(NUM_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cnt_d          = cnt_q;
    round_d        = round_q;
    u_d            = u_q;
    have_d         = have_q;
    best_reached_d = best_reached_q;
    best_d         = best_q;
    best_dist_d    = best_dist_q;
    reached_d      = reached_q;
    visited_d      = visited_q;
    pv_valid_d     = 1'b0;
    pv_idx_d       = pv_idx_q;
    dist_we        = 1'b0;
    dist_widx      = v_idx;
    dist_wdata     = '0;
    ram_raddr_o    = {u_q, v_idx};
    take           = 1'b0;
    valid_d        = 1'b0;
    vertex_d       = VERTEX_OUT_BITS'(v_idx);
    distance_d     = '0;
    reachable_d    = 1'b0;
    last_d         = 1'b0;

    alu_req_o.base     = dist_q[v_idx];
    alu_req_o.addend   = '0;
    alu_req_o.ref_dist = best_dist_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_RUN)) begin
          cnt_d          = '0;
          round_d        = '0;
          have_d         = 1'b0;
          best_reached_d = 1'b0;
          visited_d      = '0;
          reached_d      = '0;
          if (32'(source_vertex_i) < NUM_VERTICES) begin
            reached_d[src_idx] = 1'b1;
            dist_we            = 1'b1;
            dist_widx          = src_idx;
            dist_wdata         = '0;
          end
        end
      end
      ST_PICK: begin
        if (!cnt_end) begin
          cnt_d = cnt_q + CNT_BITS'(1);
          if (!visited_q[v_idx]) begin
            take = (!have_q || !best_reached_q) ? 1'b1 :
                   (reached_q[v_idx] && (alu_rsp_i.lt || alu_rsp_i.eq));
            if (take) begin
              have_d         = 1'b1;
              best_d         = v_idx;
              best_reached_d = reached_q[v_idx];
              best_dist_d    = dist_q[v_idx];
            end
          end
        end else begin
          visited_d[best_q] = 1'b1;
          u_d               = best_q;
          cnt_d             = '0;
          if (!best_reached_q) begin
            round_d = round_q + VERT_BITS'(1);
            have_d  = 1'b0;
          end
        end
      end
      ST_RELAX: begin
        alu_req_o.base     = best_dist_q;
        alu_req_o.addend   = ram_rdata_i;
        alu_req_o.ref_dist = dist_q[pv_idx_q];
        if (!cnt_end) begin
          pv_valid_d = 1'b1;
          pv_idx_d   = v_idx;
          cnt_d      = cnt_q + CNT_BITS'(1);
        end else begin
          cnt_d          = '0;
          round_d        = round_q + VERT_BITS'(1);
          have_d         = 1'b0;
          best_reached_d = 1'b0;
        end
        if (pv_valid_q && !visited_q[pv_idx_q] && (ram_rdata_i != '0) &&
            (!reached_q[pv_idx_q] || alu_rsp_i.lt)) begin
          dist_we              = 1'b1;
          dist_widx            = pv_idx_q;
          dist_wdata           = alu_rsp_i.sum;
          reached_d[pv_idx_q]  = 1'b1;
        end
      end
      ST_EMIT: begin
        cnt_d       = cnt_q + CNT_BITS'(1);
        valid_d     = 1'b1;
        reachable_d = reached_q[v_idx];
        distance_d  = reached_q[v_idx] ? OUT_DIST_BITS'(dist_q[v_idx]) : '0;
        last_d      = (cnt_q == CNT_BITS'(NUM_VERTICES - 1));
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      round_q        <= '0;
      have_q         <= 1'b0;
      best_reached_q <= 1'b0;
      reached_q      <= '0;
      visited_q      <= '0;
      pv_valid_q     <= 1'b0;
      valid_o        <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      round_q        <= round_d;
      have_q         <= have_d;
      best_reached_q <= best_reached_d;
      reached_q      <= reached_d;
      visited_q      <= visited_d;
      pv_valid_q     <= pv_valid_d;
      valid_o        <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q         <= u_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    pv_idx_q    <= pv_idx_d;
    vertex_o    <= vertex_d;
    distance_o  <= distance_d;
    reachable_o <= reachable_d;
    last_o      <= last_d;
    if (dist_we) begin
      dist_q[dist_widx] <= dist_wdata;
    end
  end

endmodule

@@ rtl/single_source_shortest_path.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// single_source_shortest_path
// Dijkstra shortest paths over a dense adjacency matrix of edge weights.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   kind_i = 0 loads weight_i into matrix entry (row_i, column_i) in that
//   cycle; busy stays low, so loads go one per cycle. Weight 0 = no edge.
//   kind_i = 1 runs from source_vertex_i; busy rises and the block holds off
//   requests until all results are out.
//   A run takes NUM_VERTICES-1 rounds. Each round scans all vertices
//   through the shared add/compare unit and, if the pick is reachable,
//   walks its matrix row through the RAM read port. Then V results stream
//   out, one per cycle, marked by valid_o, with last_o on the final one.
//   Results cannot be stalled; each is valid for exactly one cycle.
//   Reset returns the sequencer to idle; matrix contents are undefined
//   until loaded, and every entry must be loaded before the first run.
// ---------------------------------------------------------------------------
module single_source_shortest_path
  import ssp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind_i,
  input  logic [IDX_IN_BITS-1:0]     row_i,
  input  logic [IDX_IN_BITS-1:0]     column_i,
  input  logic [WEIGHT_IN_BITS-1:0]  weight_i,
  input  logic [IDX_IN_BITS-1:0]     source_vertex_i,
  output logic                       valid_o,
  output logic [VERTEX_OUT_BITS-1:0] vertex_o,
  output logic [OUT_DIST_BITS-1:0]   distance_o,
  output logic                       reachable_o,
  output logic                       last_o
);

  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]   ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  ssp_edge_ram #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(WEIGHT_BITS)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ssp_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  ssp_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .row_i          (row_i),
    .column_i       (column_i),
    .weight_i       (weight_i),
    .source_vertex_i(source_vertex_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp),
    .valid_o        (valid_o),
    .vertex_o       (vertex_o),
    .distance_o     (distance_o),
    .reachable_o    (reachable_o),
    .last_o         (last_o)
  );

  a_run_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_RUN)) |=> busy)
    else $error("run request did not raise busy");

  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result outside of a run");

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap in result stream");

  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (vertex_o == VERTEX_OUT_BITS'(NUM_VERTICES - 1)))
    else $error("last flag on wrong vertex");

endmodule
